>>> sv/fqq_pkg.sv
package fqq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	typedef enum logic [1:0] {
		FN_PUSH   = 2'd0,
		FN_POP    = 2'd1,
		FN_REV    = 2'd2,
		FN_STATUS = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OP,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic en;
	} acc_ctl_t;

	// ring position of logical element k counted from the head
	function automatic logic [IDX_W-1:0] slot_fn(input logic [IDX_W-1:0] front,
		input logic [IDX_W-1:0] k, input logic rev);
		logic [IDX_W:0] s;
		if (!rev) begin
			s = {1'b0, front} + {1'b0, k};
			if (s >= DEPTH_X)
				s = s - DEPTH_X;
		end else begin
			if (front >= k)
				s = {1'b0, front} - {1'b0, k};
			else
				s = {1'b0, front} + DEPTH_X - {1'b0, k};
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

>>> sv/fifo_queue_with_queries_unit.sv
// channel   ports                                   handshake
// request   start, func, value                      start & !busy
// result    done, popped, status, occupancy,        done, one cycle, no stall
//           largest, largest_valid, total, tens_count
//
// A request passes through an operation state, then a walk over the
// stored words through the single RAM read port, one word per cycle,
// and a step to drain the registered read. done and !busy coincide, so a
// new request may be taken in the result cycle. Reset clears the pointers and
// count; the ring store itself is not cleared. Results cannot be held off.
module fifo_queue_with_queries_unit import fqq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         func,
	input  logic signed [31:0] value,
	output logic               busy,
	output logic               done,
	output logic signed [31:0] popped,
	output logic [1:0]         status,
	output logic [4:0]         occupancy,
	output logic signed [31:0] largest,
	output logic               largest_valid,
	output logic signed [31:0] total,
	output logic [4:0]         tens_count
);

	state_t state_q, state_d;
	func_t func_q;
	stat_t status_q;
	logic signed [WORD_W-1:0] value_q, popped_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] fill_q, k_q, fill_m1;
	logic rev_q, rd_walk_s1, rd_pop_s1;

	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	logic signed [WORD_W-1:0] rdata, acc_big, acc_sum;
	logic [CNT_W-1:0] acc_tens;
	acc_ctl_t acc_ctl;

	assign fill_m1 = fill_q - 1'b1;

	fqq_ram #(.W(WORD_W), .D(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	fqq_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.data   (rdata),
		.big    (acc_big),
		.sum    (acc_sum),
		.tens   (acc_tens)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = front_q;
		raddr = front_q;
		acc_ctl.clear = 1'b0;
		acc_ctl.en = rd_walk_s1;
		case (state_q)
			ST_IDLE, ST_DONE: begin
				state_d = start ? ST_OP : ST_IDLE;
			end
			ST_OP: begin
				acc_ctl.clear = 1'b1;
				state_d = ST_WALK;
				if (func_q == FN_PUSH && fill_q < DEPTH_C) begin
					we = 1'b1;
					waddr = slot_fn(front_q, fill_q[IDX_W-1:0], rev_q);
				end
			end
			ST_WALK: begin
				raddr = slot_fn(front_q, k_q[IDX_W-1:0], rev_q);
				if (k_q == fill_q)
					state_d = ST_DONE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			fill_q <= '0;
			rev_q <= 1'b0;
			k_q <= '0;
			status_q <= STAT_OK;
			rd_walk_s1 <= 1'b0;
			rd_pop_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_OP: begin
					status_q <= STAT_OK;
					k_q <= '0;
					rd_pop_s1 <= 1'b0;
					case (func_q)
						FN_PUSH: begin
							if (fill_q >= DEPTH_C)
								status_q <= STAT_FULL;
							else
								fill_q <= fill_q + 1'b1;
						end
						FN_POP: begin
							if (fill_q == '0) begin
								status_q <= STAT_EMPTY;
							end else begin
								front_q <= slot_fn(front_q, IDX_W'(1), rev_q);
								fill_q <= fill_m1;
								rd_pop_s1 <= 1'b1;
							end
						end
						FN_REV: begin
							if (fill_q != '0) begin
								front_q <= slot_fn(front_q, fill_m1[IDX_W-1:0], rev_q);
								rev_q <= ~rev_q;
							end
						end
						default: ;
					endcase
				end
				ST_WALK: begin
					rd_pop_s1 <= 1'b0;
					if (k_q < fill_q) begin
						k_q <= k_q + 1'b1;
						rd_walk_s1 <= 1'b1;
					end else begin
						rd_walk_s1 <= 1'b0;
					end
				end
				default: begin
					rd_walk_s1 <= 1'b0;
					rd_pop_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE || state_q == ST_DONE) && start) begin
			func_q <= func_t'(func);
			value_q <= value;
		end
		if (state_q == ST_OP)
			popped_q <= '0;
		else if (state_q == ST_WALK && rd_pop_s1)
			popped_q <= rdata;
	end

	assign busy = (state_q == ST_OP) || (state_q == ST_WALK);
	assign done = (state_q == ST_DONE);
	assign popped = popped_q;
	assign status = status_q;
	assign occupancy = 5'(fill_q);
	assign largest_valid = (fill_q != '0);
	assign largest = (fill_q != '0) ? acc_big : '0;
	assign total = acc_sum;
	assign tens_count = 5'(acc_tens);

endmodule

>>> sv/fqq_ram.sv
module fqq_ram #(
	parameter int W = 32,
	parameter int D = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> sv/fqq_acc.sv
module fqq_acc import fqq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  acc_ctl_t                 ctl,
	input  logic signed [WORD_W-1:0] data,
	output logic signed [WORD_W-1:0] big,
	output logic signed [WORD_W-1:0] sum,
	output logic [CNT_W-1:0]         tens
);

	logic signed [WORD_W-1:0] big_q, sum_q;
	logic [CNT_W-1:0] tens_q;
	logic first_q;
	logic is_ten;

	// 16 == 1 mod 5, so nibble sums keep the residue
	function automatic logic div5(input logic [WORD_W-1:0] m);
		logic [6:0] s;
		logic [4:0] r;
		s = '0;
		for (int i = 0; i < 8; i++)
			s = s + 7'(m[i*4 +: 4]);
		r = 5'(s[6:4]) + 5'(s[3:0]);
		if (r >= 5'd20)
			r = r - 5'd20;
		if (r >= 5'd10)
			r = r - 5'd10;
		if (r >= 5'd5)
			r = r - 5'd5;
		return r == 5'd0;
	endfunction

	always_comb begin
		logic [WORD_W-1:0] mag;
		mag = data[WORD_W-1] ? (~data + 1'b1) : data;
		is_ten = !data[0] && div5(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			tens_q <= '0;
		end else if (ctl.clear) begin
			first_q <= 1'b1;
			tens_q <= '0;
		end else if (ctl.en) begin
			first_q <= 1'b0;
			if (is_ten)
				tens_q <= tens_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			sum_q <= '0;
			big_q <= '0;
		end else if (ctl.en) begin
			sum_q <= sum_q + data;
			if (first_q || data > big_q)
				big_q <= data;
		end
	end

	assign big = big_q;
	assign sum = sum_q;
	assign tens = tens_q;

endmodule

>>> sv/fqq_checker.sv
module fqq_checker import fqq_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] popped,
	input logic [1:0]         status,
	input logic [4:0]         occupancy,
	input logic               largest_valid
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy next cycle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_valid_occ: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (largest_valid == (occupancy != 5'd0)))
		else $error("largest_valid disagrees with occupancy");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_EMPTY |-> popped == 32'sd0 && occupancy == 5'd0)
		else $error("failed pop reports data or nonzero occupancy");

endmodule

bind fifo_queue_with_queries_unit fqq_checker u_fqq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.popped        (popped),
	.status        (status),
	.occupancy     (occupancy),
	.largest_valid (largest_valid)
);

>>> bench/fifo_queue_with_queries_unit_test.sv
module fifo_queue_with_queries_unit_test import fqq_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQS = 1525;
	localparam int QUIET_TAIL = 200;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		func_t       fn;
		logic [31:0] word;
		bit          drain_first;
	} request_t;

	typedef struct {
		logic [31:0] popped;
		stat_t       stat;
		logic [4:0]  occ;
		logic [31:0] top;
		logic        top_ok;
		logic [31:0] sum;
		logic [4:0]  tens;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] func = FN_STATUS;
	logic signed [31:0] value = '0;
	logic busy, done;
	logic signed [31:0] popped, largest, total;
	logic [1:0] status;
	logic [4:0] occupancy, tens_count;
	logic largest_valid;

	request_t pend[$];
	outcome_t due_results[$];
	logic taken = 1'b0;
	int gap_left = 0;
	int errors = 0;
	int cycles = 0;

	// queue shadow
	logic [31:0] ring [DEPTH];
	logic [IDX_W-1:0] head = '0;
	logic [CNT_W-1:0] fill = '0;
	logic flipped = 1'b0;

	fifo_queue_with_queries_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.func(func),
		.value(value),
		.busy(busy),
		.done(done),
		.popped(popped),
		.status(status),
		.occupancy(occupancy),
		.largest(largest),
		.largest_valid(largest_valid),
		.total(total),
		.tens_count(tens_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [IDX_W-1:0] ring_pos(input int k);
		int off;
		off = k % DEPTH;
		if (flipped)
			return IDX_W'((int'(head) + DEPTH - off) % DEPTH);
		return IDX_W'((int'(head) + off) % DEPTH);
	endfunction

	function automatic void queue_model_step(input func_t fn, input logic [31:0] word,
		output outcome_t o);
		logic [31:0] v, mag;
		o.popped = '0;
		o.stat = STAT_OK;
		o.top = '0;
		o.sum = '0;
		o.tens = '0;
		case (fn)
			FN_PUSH: begin
				if (fill >= DEPTH) begin
					o.stat = STAT_FULL;
				end else begin
					ring[ring_pos(int'(fill))] = word;
					fill = fill + 1'b1;
				end
			end
			FN_POP: begin
				if (fill == 0) begin
					o.stat = STAT_EMPTY;
				end else begin
					o.popped = ring[ring_pos(0)];
					head = ring_pos(1);
					fill = fill - 1'b1;
				end
			end
			FN_REV: begin
				if (fill != 0) begin
					head = ring_pos(int'(fill) - 1);
					flipped = ~flipped;
				end
			end
			default: ;
		endcase
		for (int k = 0; k < int'(fill); k++) begin
			v = ring[ring_pos(k)];
			if (k == 0 || $signed(v) > $signed(o.top))
				o.top = v;
			o.sum = o.sum + v;
			mag = v[31] ? (32'd0 - v) : v;
			if (!v[0] && (mag % 32'd5) == 0)
				o.tens = o.tens + 1'b1;
		end
		o.occ = 5'(fill);
		o.top_ok = (fill != 0);
	endfunction

	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		case ($urandom_range(0, 5))
			0: w = $urandom();
			1: begin
				case ($urandom_range(0, 3))
					0: w = 32'h8000_0000;
					1: w = 32'h7fff_ffff;
					2: w = 32'h0000_0000;
					default: w = 32'hffff_ffff;
				endcase
			end
			2: w = 32'($urandom_range(0, 400) * 10);
			3: w = 32'($urandom_range(0, 400) * 10 + 5);
			4: w = 32'($signed($urandom_range(0, 6)) - 3);
			default: w = $urandom();
		endcase
		if ($urandom_range(0, 1))
			w = 32'd0 - w;
		return w;
	endfunction

	task automatic add_request(input func_t fn, input logic [31:0] word, input bit hold);
		request_t r;
		r.fn = fn;
		r.word = word;
		r.drain_first = hold;
		pend.push_back(r);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(negedge clk) begin : driver
		logic go;
		request_t r;
		go = start;
		if (!arst_n) begin
			go = 1'b0;
		end else begin
			if (start && taken)
				go = 1'b0;
			if (!go) begin
				if (gap_left != 0) begin
					gap_left = gap_left - 1;
				end else if (pend.size() != 0 &&
					!(pend[0].drain_first && due_results.size() != 0)) begin
					r = pend.pop_front();
					func <= r.fn;
					value <= r.word;
					go = 1'b1;
					if (pend.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
						gap_left = $urandom_range(1, 11);
				end
			end
		end
		start <= go;
	end

	always @(posedge clk) begin : monitor
		outcome_t exp_r, nxt;
		if (arst_n) begin
			taken <= start && !busy;
			if (done) begin
				if (due_results.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					exp_r = due_results.pop_front();
					if (popped !== exp_r.popped) begin
						$error("popped: expected %0d, got %0d", $signed(exp_r.popped), popped);
						errors++;
					end
					if (status !== exp_r.stat) begin
						$error("status: expected %0d, got %0d", exp_r.stat, status);
						errors++;
					end
					if (occupancy !== exp_r.occ) begin
						$error("occupancy: expected %0d, got %0d", exp_r.occ, occupancy);
						errors++;
					end
					if (largest !== exp_r.top) begin
						$error("largest: expected %0d, got %0d", $signed(exp_r.top), largest);
						errors++;
					end
					if (largest_valid !== exp_r.top_ok) begin
						$error("largest_valid: expected %0d, got %0d", exp_r.top_ok,
							largest_valid);
						errors++;
					end
					if (total !== exp_r.sum) begin
						$error("total: expected %0d, got %0d", $signed(exp_r.sum), total);
						errors++;
					end
					if (tens_count !== exp_r.tens) begin
						$error("tens_count: expected %0d, got %0d", exp_r.tens, tens_count);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				queue_model_step(func_t'(func), value, nxt);
				due_results.push_back(nxt);
			end
		end
	end

	initial begin : stimulus
		int n, mode, run, pick;
		func_t fn;

		// empty-queue corners, then extreme words, a reversal and a fill to full depth
		add_request(FN_POP, 32'h1234_5678, 1'b0);
		add_request(FN_REV, 32'hffff_ffff, 1'b0);
		add_request(FN_STATUS, 32'h0, 1'b0);
		add_request(FN_PUSH, 32'h8000_0000, 1'b0);
		add_request(FN_PUSH, 32'h7fff_ffff, 1'b0);
		add_request(FN_PUSH, 32'hffff_fff6, 1'b0);
		add_request(FN_PUSH, 32'h0, 1'b0);
		add_request(FN_REV, 32'h0, 1'b0);
		add_request(FN_POP, 32'h0, 1'b0);
		add_request(FN_PUSH, 32'd30, 1'b0);
		for (int i = 0; i < 12; i++)
			add_request(FN_PUSH, (i % 2) ? 32'd5 * i : 32'd0 - 32'd10 * i, 1'b0);
		// full queue drops the word
		add_request(FN_PUSH, 32'h5555_aaaa, 1'b0);
		add_request(FN_REV, 32'h0, 1'b0);
		add_request(FN_POP, 32'h0, 1'b0);

		n = 0;
		while (n < RANDOM_REQS) begin
			mode = $urandom_range(0, 3);
			run = $urandom_range(5, 40);
			for (int i = 0; i < run && n < RANDOM_REQS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					fn = FN_REV;
				else if (pick < 12)
					fn = FN_STATUS;
				else if (mode == 0)
					fn = (pick < 80) ? FN_PUSH : FN_POP;
				else if (mode == 1)
					fn = (pick < 80) ? FN_POP : FN_PUSH;
				else if (mode == 2)
					fn = (pick < 56) ? FN_PUSH : FN_POP;
				else
					fn = func_t'($urandom_range(0, 3));
				add_request(fn, pick_word(), (n == 0) || ($urandom_range(0, 149) == 0));
				n++;
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pend.size() != 0 || start || due_results.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d results never arrived", due_results.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
